FILE: hw/rtl/fspa_pkg.sv
// Package for the fixed-size pool allocator: request/result structs,
// request kinds, register indexes and field widths.
// No dependencies.
package fspa_pkg;

    localparam int SLOT_W   = 10;
    localparam int OFFS_W   = 22;
    localparam int ELEM_W   = 13;
    localparam int BLOCK_W  = 11;
    localparam int CFG_W    = 13;

    // request kinds
    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_FREE     = 2'd1;
    localparam logic [1:0] KIND_FREE_ALL = 2'd2;

    // configuration register indexes
    localparam logic REG_ELEM_SIZE  = 1'b0;
    localparam logic REG_BLOCK_SIZE = 1'b1;

    localparam logic [ELEM_W-1:0]  ELEM_RESET  = 13'd8;
    localparam logic [BLOCK_W-1:0] BLOCK_RESET = 11'd16;
    localparam logic [ELEM_W-1:0]  ELEM_MIN    = 13'd8;
    localparam logic [ELEM_W-1:0]  ELEM_MAX    = 13'd4096;
    localparam logic [BLOCK_W-1:0] BLOCK_MAX   = 11'd1024;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot_out;
        logic [OFFS_W-1:0] byte_offset;
        logic              recycled;
    } t_res;

    // one free-list entry: link to next slot and whether that link is live
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] link;
    } t_link;

endpackage

FILE: hw/rtl/fixed_size_pool_allocator.sv
// Fixed-size pool allocator top level: LIFO free list in RAM plus bump region.
// Depends on fspa_pkg and fspa_ram.
//
// One request at a time: a request is taken when start is high and busy is
// low, and its result appears on o_res for exactly one cycle with o_valid
// high; it cannot be held off. A free-list pop goes through the link RAM
// read, the head update and the byte-offset multiply into the output
// register. A bump allocation goes through the block base multiply, the
// fill add with the pool range check, and the same offset multiply. A free
// has only the offset multiply after acceptance. Free-all, unused kinds,
// refused frees and bump allocations past the last block answer in the
// cycle after acceptance. A bump allocation past the last slot of the pool
// is refused at the range check. busy drops in the cycle the result is
// shown, so the next request may be taken then. Writing either
// configuration register resets the pool as a free-all does; write only
// while the block is idle.
module fixed_size_pool_allocator #(
    parameter int POOL_SLOTS = 1024,
    parameter int MAX_BLOCKS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fspa_pkg::t_req             i_req,
    output logic                       o_valid,
    output fspa_pkg::t_res             o_res,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [fspa_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int AW  = $clog2(POOL_SLOTS);
    localparam int BNW = $clog2(MAX_BLOCKS + 1);
    localparam int PW  = BNW + fspa_pkg::BLOCK_W;
    localparam int SW  = fspa_pkg::SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_BUMP = 4'b0100,
        S_MUL  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [fspa_pkg::ELEM_W-1:0]  r_elem_size;
    logic [fspa_pkg::BLOCK_W-1:0] r_block_size;

    logic [SW-1:0]  r_head, n_head;
    logic           r_nonempty, n_nonempty;
    logic [SW-1:0]  r_fill, n_fill;
    logic [BNW-1:0] r_blk, n_blk;
    logic           r_started, n_started;
    logic           r_valid, n_valid;

    // payload registers
    logic [SW-1:0]    r_slot, n_slot;
    logic             r_rec, n_rec;
    logic [PW-1:0]    r_prod, n_prod;
    logic [SW-1:0]    r_nf, n_nf;
    logic [BNW-1:0]   r_nb, n_nb;
    fspa_pkg::t_res   r_res, n_res;

    logic [fspa_pkg::ELEM_W-1:0]  w_es;
    logic [fspa_pkg::BLOCK_W-1:0] w_bs;
    logic [fspa_pkg::BLOCK_W-1:0] w_cfg_bs;
    logic [fspa_pkg::BLOCK_W-1:0] w_nf;
    logic                         w_wrap;
    logic [BNW:0]                 w_nb;
    logic                         w_bump_bad;
    logic [PW:0]                  w_sum;
    logic [31:0]                  w_sum32;
    logic [31:0]                  w_req_slot32;
    logic [31:0]                  w_head32;
    logic                         w_slot_bad;
    logic [22:0]                  w_offset;
    logic                         w_accept;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    fspa_pkg::t_link    w_wlink;
    fspa_pkg::t_link    w_rlink;

    // effective register values, saturated
    always_comb begin
        if (r_elem_size < fspa_pkg::ELEM_MIN) begin
            w_es = fspa_pkg::ELEM_MIN;
        end else if (r_elem_size > fspa_pkg::ELEM_MAX) begin
            w_es = fspa_pkg::ELEM_MAX;
        end else begin
            w_es = r_elem_size;
        end
    end

    function automatic logic [fspa_pkg::BLOCK_W-1:0] sat_block(
        input logic [fspa_pkg::BLOCK_W-1:0] b
    );
        logic [fspa_pkg::BLOCK_W-1:0] r;
        if (b == '0) begin
            r = fspa_pkg::BLOCK_W'(1);
        end else if (b > fspa_pkg::BLOCK_MAX) begin
            r = fspa_pkg::BLOCK_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

    assign w_bs     = sat_block(r_block_size);
    assign w_cfg_bs = sat_block(i_cfg_wdata[fspa_pkg::BLOCK_W-1:0]);

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // bump step
    assign w_nf   = {1'b0, r_fill} + fspa_pkg::BLOCK_W'(1);
    assign w_wrap = (w_nf >= w_bs);
    always_comb begin
        if (w_wrap) begin
            w_nb = r_started ? ({1'b0, r_blk} + (BNW+1)'(1)) : '0;
        end else begin
            w_nb = {1'b0, r_blk};
        end
    end
    // block number still minus one without a wrap, or past the last block
    assign w_bump_bad = (!w_wrap && !r_started) || (w_nb >= (BNW+1)'(MAX_BLOCKS));

    assign w_sum   = {1'b0, r_prod} + (PW+1)'(r_nf);
    assign w_sum32 = 32'(w_sum);

    assign w_req_slot32 = 32'(i_req.slot);
    assign w_head32     = 32'(r_head);
    assign w_slot_bad   = (w_req_slot32 >= 32'(POOL_SLOTS));

    assign w_offset = 23'(r_slot) * 23'(w_es);

    // link RAM: push writes at the request slot, pop reads at the head
    assign w_we       = w_accept && (i_req.kind == fspa_pkg::KIND_FREE) && !w_slot_bad;
    assign w_waddr    = w_req_slot32[AW-1:0];
    assign w_raddr    = w_head32[AW-1:0];
    assign w_wlink    = '{valid: r_nonempty, link: r_head};

    fspa_ram #(
        .WIDTH ($bits(fspa_pkg::t_link)),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wlink),
        .i_raddr (w_raddr),
        .o_rdata (w_rlink)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_nonempty = r_nonempty;
        n_fill     = r_fill;
        n_blk      = r_blk;
        n_started  = r_started;
        n_valid    = 1'b0;
        n_slot     = r_slot;
        n_rec      = r_rec;
        n_prod     = r_prod;
        n_nf       = r_nf;
        n_nb       = r_nb;
        n_res      = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    priority if (i_req.kind == fspa_pkg::KIND_ALLOC) begin
                        if (r_nonempty) begin
                            n_slot  = r_head;
                            n_rec   = 1'b1;
                            n_state = S_READ;
                        end else if (w_bump_bad) begin
                            n_res   = '0;
                            n_res.status = 1'b1;
                            n_valid = 1'b1;
                        end else begin
                            n_nb    = w_nb[BNW-1:0];
                            n_nf    = w_wrap ? '0 : w_nf[SW-1:0];
                            n_prod  = PW'(w_nb[BNW-1:0]) * PW'(w_bs);
                            n_rec   = 1'b0;
                            n_state = S_BUMP;
                        end
                    end else if (i_req.kind == fspa_pkg::KIND_FREE) begin
                        if (w_slot_bad) begin
                            n_res   = '0;
                            n_res.status = 1'b1;
                            n_valid = 1'b1;
                        end else begin
                            n_head     = i_req.slot;
                            n_nonempty = 1'b1;
                            n_slot     = i_req.slot;
                            n_rec      = 1'b0;
                            n_state    = S_MUL;
                        end
                    end else if (i_req.kind == fspa_pkg::KIND_FREE_ALL) begin
                        n_fill     = SW'(w_bs - fspa_pkg::BLOCK_W'(1));
                        n_started  = 1'b0;
                        n_blk      = '0;
                        n_head     = '0;
                        n_nonempty = 1'b0;
                        n_res      = '0;
                        n_valid    = 1'b1;
                    end else begin
                        n_res   = '0;
                        n_valid = 1'b1;
                    end
                end else if (i_cfg_we) begin
                    n_fill = (i_cfg_idx == fspa_pkg::REG_BLOCK_SIZE) ?
                             SW'(w_cfg_bs - fspa_pkg::BLOCK_W'(1)) :
                             SW'(w_bs - fspa_pkg::BLOCK_W'(1));
                    n_started  = 1'b0;
                    n_blk      = '0;
                    n_head     = '0;
                    n_nonempty = 1'b0;
                end
            end
            S_READ: begin
                n_head     = w_rlink.link;
                n_nonempty = w_rlink.valid;
                n_state    = S_MUL;
            end
            S_BUMP: begin
                if (w_sum32 >= 32'(POOL_SLOTS)) begin
                    n_res   = '0;
                    n_res.status = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_fill    = r_nf;
                    n_blk     = r_nb;
                    n_started = 1'b1;
                    n_slot    = w_sum[SW-1:0];
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                n_res.status      = 1'b0;
                n_res.slot_out    = r_slot;
                n_res.byte_offset = w_offset[fspa_pkg::OFFS_W-1:0];
                n_res.recycled    = r_rec;
                n_valid           = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_elem_size  <= fspa_pkg::ELEM_RESET;
            r_block_size <= fspa_pkg::BLOCK_RESET;
            r_head       <= '0;
            r_nonempty   <= 1'b0;
            r_fill       <= SW'(fspa_pkg::BLOCK_RESET - fspa_pkg::BLOCK_W'(1));
            r_blk        <= '0;
            r_started    <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_nonempty <= n_nonempty;
            r_fill     <= n_fill;
            r_blk      <= n_blk;
            r_started  <= n_started;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == fspa_pkg::REG_ELEM_SIZE) begin
                    r_elem_size <= i_cfg_wdata;
                end else begin
                    r_block_size <= i_cfg_wdata[fspa_pkg::BLOCK_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_rec  <= n_rec;
        r_prod <= n_prod;
        r_nf   <= n_nf;
        r_nb   <= n_nb;
        r_res  <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/fspa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
